// ===== src/i2crb_pkg.sv =====
// Shared constants for the I2C slave register buffer.
// No dependencies.
`default_nettype none

package i2crb_pkg;

  // Bus event codes carried on cmd and echoed on event_echo
  localparam logic [3:0] CMD_WRITE_ADDR = 4'd0;
  localparam logic [3:0] CMD_RX_ACK     = 4'd1;
  localparam logic [3:0] CMD_RX_NACK    = 4'd2;
  localparam logic [3:0] CMD_STOP       = 4'd3;
  localparam logic [3:0] CMD_READ_ADDR  = 4'd4;
  localparam logic [3:0] CMD_TX_ACK     = 4'd5;
  localparam logic [3:0] CMD_TX_NACK    = 4'd6;
  localparam logic [3:0] CMD_LAST_TX    = 4'd7;
  localparam logic [3:0] CMD_OTHER      = 4'd8;

  // Configuration register indexes
  localparam logic CFG_POSITION_LIMIT  = 1'b0;
  localparam logic CFG_ADDRESSING_MODE = 1'b1;

  // Addressing modes
  localparam logic MODE_RESTART = 1'b0;
  localparam logic MODE_ADDRESS = 1'b1;

  // Response codes
  localparam logic RESP_ACK     = 1'b0;
  localparam logic RESP_RELEASE = 1'b1;

endpackage

`default_nettype wire

// ===== src/i2crb_ram.sv =====
// Generic single-write, single-read RAM with a registered, read-enabled output.
// No dependencies.
`default_nettype none

module i2crb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, output holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/i2c_slave_register_buffer_core.sv =====
// Top level of the I2C slave register buffer: event decode, position control, byte store.
// Depends on i2crb_pkg and i2crb_ram.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one bus event per transaction:
//   cmd and, for a received byte, rx_byte. Output channel (out_valid /
//   out_stall) returns one result per event: tx_byte, tx_valid, response and
//   event_echo.
//   Each event passes through ST_IDLE and ST_EXEC: on accept the block issues
//   the byte store read; ST_EXEC uses the registered read data and, once the
//   output is free, updates position and the address flag, writes the store
//   and loads the output register, raising out_valid. The store read is
//   registered, so execution follows the accept; no new event is taken until
//   ST_EXEC has loaded the result.
//   A result waiting in the output register does not block the next accept;
//   if it is still stalled when the following result is ready, the block
//   holds that result and keeps in_stall high until the output frees up.
//   Configuration (cfg_we, cfg_index, cfg_data) must be written only while idle;
//   the block does not enforce it. Reset holds in_stall high and clears
//   position, the address flag, both registers and each entry's valid bit; an
//   unwritten entry reads as zero: no clearing pass, events are taken right after.
`default_nettype none

module i2c_slave_register_buffer_core
  import i2crb_pkg::*;
#(
  parameter int STORE_DEPTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration write port
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  // event channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [3:0] cmd,
  input  wire logic [7:0] rx_byte,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] tx_byte,
  output logic            tx_valid,
  output logic            response,
  output logic      [3:0] event_echo
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [7:0] MAX_POS = 8'(STORE_DEPTH - 1);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  // configuration
  logic [7:0] position_limit;
  logic       addressing_mode;

  // buffer control state
  logic [7:0] position;
  logic       expect_address;
  logic [STORE_DEPTH-1:0] written;

  // event held for the execute cycle
  logic [3:0] ev_cmd;
  logic [7:0] ev_rx;
  logic       rd_written;

  // store port signals
  logic          in_accept;
  logic          out_free;
  logic [7:0]    rd_pos;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  // execute results
  logic [7:0] lim;
  logic [7:0] base_pos;
  logic [7:0] adv_pos;
  logic [7:0] position_next;
  logic       expect_address_next;
  logic [7:0] tx_byte_next;
  logic       tx_valid_next;
  logic       response_next;
  logic       finish;

  assign in_stall  = rst || (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign finish    = (state == ST_EXEC) && out_free;

  // Pick the read position: a read-addressed event in restart mode reads entry zero
  always_comb begin
    if (cmd == CMD_READ_ADDR && addressing_mode == MODE_RESTART) begin
      rd_pos = 8'd0;
    end else begin
      rd_pos = position;
    end
  end
  assign rd_addr = rd_pos[AW-1:0];

  i2crb_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(ev_rx),
    .re   (in_accept),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Effective limit never points past the store
  assign lim = (position_limit > MAX_POS) ? MAX_POS : position_limit;

  // Execute: decode the held event, advance position, build the result
  always_comb begin
    position_next       = position;
    expect_address_next = expect_address;
    tx_byte_next        = 8'd0;
    tx_valid_next       = 1'b0;
    response_next       = RESP_ACK;
    wr_en               = 1'b0;
    wr_addr             = position[AW-1:0];
    if (ev_cmd == CMD_READ_ADDR && addressing_mode == MODE_RESTART) begin
      base_pos = 8'd0;
    end else begin
      base_pos = position;
    end
    adv_pos = (base_pos < lim) ? base_pos + 8'd1 : 8'd0;

    case (ev_cmd)
      CMD_WRITE_ADDR: begin
        if (addressing_mode == MODE_RESTART) begin
          position_next       = 8'd0;
          expect_address_next = 1'b0;
        end else begin
          expect_address_next = 1'b1;
        end
      end
      CMD_RX_ACK: begin
        if (expect_address) begin
          if (ev_rx <= lim) begin
            position_next = ev_rx;
          end
          expect_address_next = 1'b0;
        end else begin
          wr_en         = finish;
          position_next = adv_pos;
        end
      end
      CMD_STOP: begin
      end
      CMD_READ_ADDR, CMD_TX_ACK: begin
        tx_byte_next  = rd_written ? rd_data : 8'd0;
        tx_valid_next = 1'b1;
        position_next = adv_pos;
      end
      default: begin
        response_next = RESP_RELEASE;
      end
    endcase
  end

  // Hold state, registers and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      position_limit  <= 8'd0;
      addressing_mode <= MODE_RESTART;
      position        <= 8'd0;
      expect_address  <= 1'b0;
      written         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_POSITION_LIMIT:  position_limit  <= cfg_data;
          CFG_ADDRESSING_MODE: addressing_mode <= cfg_data[0];
          default: begin
          end
        endcase
      end

      // Drop the taken result unless a new one loads in this cycle
      if (out_valid && !out_stall && !finish) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            ev_cmd     <= cmd;
            ev_rx      <= rx_byte;
            rd_written <= written[rd_addr];
            state      <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            position       <= position_next;
            expect_address <= expect_address_next;
            if (wr_en) begin
              written[wr_addr] <= 1'b1;
            end
            tx_byte    <= tx_byte_next;
            tx_valid   <= tx_valid_next;
            response   <= response_next;
            event_echo <= ev_cmd;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Only read events load a transmit byte
  a_tx_only_on_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && tx_valid |-> event_echo == CMD_READ_ADDR || event_echo == CMD_TX_ACK)
    else $error("tx_valid on a non-read event");

  // A released event never carries a transmit byte
  a_release_no_tx: assert property (@(posedge clk) disable iff (rst)
    out_valid && response == RESP_RELEASE |-> !tx_valid && tx_byte == 8'd0)
    else $error("released event carries transmit data");

  // Position stays inside the store
  a_position_in_store: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> position <= MAX_POS)
    else $error("position beyond store");

  // An accepted event always goes to the execute cycle
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == ST_EXEC)
    else $error("accepted event not executed");

endmodule

`default_nettype wire
